### rtl/sha1_digest_macros.svh
// ----------------------------------------------------------------------------
// sha1_digest_macros
// concurrent assertion shorthands shared by sha1_front and sha1_back
// ----------------------------------------------------------------------------
`ifndef SHA1_DIGEST_MACROS_SVH
`define SHA1_DIGEST_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and round helpers for the sha1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [6:0] LAST_ROUND    = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [7:0] PAD_BYTE      = 8'h80;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] chain_t;

	localparam chain_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       message_end;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} state_t;

	function automatic word_t round_k(input logic [6:0] r);
		word_t k;
		if (r < 7'd20) begin
			k = K0;
		end else if (r < 7'd40) begin
			k = K1;
		end else if (r < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic word_t round_f(input logic [6:0] r, input word_t b,
			input word_t c, input word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40 || r >= 7'd60) begin
			f = b ^ c ^ d;
		end else begin
			f = (b & c) | (b & d) | (c & d);
		end
		return f;
	endfunction

endpackage

### rtl/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// input side: takes byte beats, drops empty ones, queues the rest
// ----------------------------------------------------------------------------
`include "sha1_digest_macros.svh"

module sha1_front
	import sha1_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] has_byte
	input  logic       s_tlast,   // message_end
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign s_tready  = (count_q != CNT_W'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// beats with no byte and no end carry nothing
	assign push = s_tvalid && s_tready && (s_tuser || s_tlast);
	assign pop  = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{data_byte: s_tdata, has_byte: s_tuser,
				message_end: s_tlast};
		end
	end

	`SHA1_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count over depth")
	`SHA1_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a beat")

endmodule

### rtl/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back
// block packing, padding, 80-round compression and digest output register
// ----------------------------------------------------------------------------
`include "sha1_digest_macros.svh"

module sha1_back
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);

	state_t      state_q;
	state_t      state_d;
	state_t      after_q;
	state_t      after_d;
	logic [5:0]  pos_q;
	logic [60:0] len_q;
	logic [6:0]  round_q;
	logic [2:0]  idx_q;
	logic        pad_first_q;
	logic        len_ok_q;
	chain_t      chain_q;
	logic [23:0] acc_q;
	word_t       sched_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tlast_q;

	logic        put_byte;
	logic [7:0]  put_val;
	logic        len_inc;
	logic        go_round;
	logic        load_out;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	word_t       sched_x;
	word_t       sched_new;
	word_t       t_sum;

	assign len_bits  = {len_q, 3'b000};
	assign len_byte  = len_bits[{~pos_q[2:0], 3'b000} +: 8];
	assign sched_x   = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign sched_new = {sched_x[30:0], sched_x[31]};
	assign t_sum     = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q)
		+ e_q + round_k(round_q) + sched_q[0];

	always_comb begin
		state_d   = state_q;
		after_d   = after_q;
		cmd_ready = 1'b0;
		put_byte  = 1'b0;
		put_val   = cmd.data_byte;
		len_inc   = 1'b0;
		go_round  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd.has_byte) begin
						put_byte = 1'b1;
						len_inc  = 1'b1;
					end
					if (cmd.has_byte && pos_q == LAST_POS) begin
						go_round = 1'b1;
						state_d  = ST_ROUND;
						after_d  = cmd.message_end ? ST_PAD : ST_IDLE;
					end else if (cmd.message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = after_q;
			end
			ST_PAD: begin
				put_byte = 1'b1;
				if (pad_first_q) begin
					put_val = PAD_BYTE;
				end else if (len_ok_q && pos_q >= LEN_POS) begin
					put_val = len_byte;
				end else begin
					put_val = '0;
				end
				if (pos_q == LAST_POS) begin
					go_round = 1'b1;
					state_d  = ST_ROUND;
					after_d  = (!pad_first_q && len_ok_q) ? ST_EMIT : ST_PAD;
				end
			end
			ST_EMIT: begin
				load_out = !m_tvalid_q || m_tready;
				if (load_out && idx_q == LAST_WORD_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			after_q     <= ST_IDLE;
			pos_q       <= '0;
			len_q       <= '0;
			round_q     <= '0;
			idx_q       <= '0;
			pad_first_q <= 1'b1;
			len_ok_q    <= 1'b0;
			chain_q     <= INIT_CHAIN;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			if (put_byte) begin
				pos_q <= pos_q + 1'b1;
			end
			if (len_inc) begin
				len_q <= len_q + 1'b1;
			end
			if (state_q == ST_IDLE) begin
				pad_first_q <= 1'b1;
			end else if (state_q == ST_PAD) begin
				if (pad_first_q) begin
					pad_first_q <= 1'b0;
					len_ok_q    <= (pos_q < LEN_POS) || (pos_q == LAST_POS);
				end else if (pos_q == LAST_POS) begin
					len_ok_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == LAST_ROUND) ? '0 : round_q + 1'b1;
			end
			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				if (idx_q == LAST_WORD_IDX) begin
					idx_q   <= '0;
					chain_q <= INIT_CHAIN;
					len_q   <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (put_byte) begin
			if (pos_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) begin
					sched_q[i] <= sched_q[i + 1];
				end
				sched_q[15] <= {acc_q, put_val};
			end else begin
				acc_q <= {acc_q[15:0], put_val};
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= sched_new;
		end
		if (go_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (load_out) begin
			m_tdata_q <= chain_q[idx_q];
			m_tuser_q <= idx_q;
			m_tlast_q <= (idx_q == LAST_WORD_IDX);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`SHA1_ASSERT_SAME(a_round_bound, 1'b1, round_q <= LAST_ROUND, "round counter past last round")
	`SHA1_ASSERT_NEXT(a_round_done, state_q == ST_ROUND && round_q == LAST_ROUND, state_q == ST_ADD, "compression did not finish")
	`SHA1_ASSERT_SAME(a_last_word, m_tvalid_q, m_tlast_q == (m_tuser_q == LAST_WORD_IDX), "last flag off the final word")

endmodule

### rtl/sha1_digest.sv
// ----------------------------------------------------------------------------
// sha1_digest
// streaming sha1 over a byte-serial message, five digest words per message
// ----------------------------------------------------------------------------
// input beat: tdata carries one message byte, tuser says the byte is present,
// tlast ends the message after that byte. beats with neither are dropped.
// output beat: tdata is a 32-bit digest word, tuser its index 0 to 4, tlast
// marks index 4. five beats follow every message end.
// the input side takes one beat a cycle into a small queue while it has room;
// the back end packs one byte a cycle while idle, and every 64th byte starts
// the round unit, which runs one round a cycle for 80 rounds and then does
// the chaining add. at the end the back end writes padding one byte a cycle
// to the block end (into a second block if the length field spills over),
// and then the digest leaves one word a cycle through the output register
// while the receiver takes them.
// reset empties the queue and loads the initial chaining value.
// when the receiver stalls, the output register holds its word, the back end
// waits, the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module sha1_digest
	import sha1_pkg::*;
#(
	parameter int unsigned CMD_QUEUE_DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	sha1_front #(
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	sha1_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
